>>> rtl/bbe_pkg.sv
package bbe_pkg;

  localparam int MAX_WORDS = 4;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int WCNT_W    = $clog2(MAX_WORDS + 1);
  localparam int WIDX_W    = $clog2(MAX_WORDS);

  localparam logic [7:0] TERM_BYTE = 8'hFF;

  localparam logic [2:0] CFG_PUSH_LOCALS     = 3'd0;
  localparam logic [2:0] CFG_FETCH_PROPERTY  = 3'd1;
  localparam logic [2:0] CFG_CREATE_PROPERTY = 3'd2;
  localparam logic [2:0] CFG_STORE           = 3'd3;
  localparam logic [2:0] CFG_POP             = 3'd4;
  localparam logic [2:0] CFG_BASE_PUSH_CONST = 3'd5;
  localparam logic [2:0] CFG_BASE_LAZY_CALL  = 3'd6;

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_INT_FIRST,
    PH_INT_SECOND,
    PH_INT_LONG,
    PH_COUNT
  } phase_t;

  typedef enum logic [1:0] {
    PU_FETCH,
    PU_CREATE,
    PU_CONST,
    PU_ARG
  } purpose_t;

  typedef enum logic [1:0] {
    ST_FETCH,
    ST_CREATE,
    ST_BASE,
    ST_POST
  } stage_t;

  typedef struct packed {
    logic [15:0] push_locals;
    logic [15:0] fetch_property;
    logic [15:0] create_property;
    logic [15:0] store;
    logic [15:0] pop;
    logic [2:0]  base_push_const;
    logic [2:0]  base_lazy_call;
  } cfg_t;

  // all words caused by one input byte
  typedef struct packed {
    logic [MAX_WORDS-1:0][15:0] words;
    logic [WCNT_W-1:0]          cnt;
    logic                       block_end;
  } job_t;

endpackage

>>> rtl/bbe_front.sv
module bbe_front
  import bbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  phase_t      phase_r, phase_nxt;
  purpose_t    purpose_r, purpose_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [15:0] mag_r, mag_nxt;
  logic        sign_r, sign_nxt;
  logic [4:0]  long_left_r, long_left_nxt;
  logic [7:0]  call_left_r, call_left_nxt;

  logic                       accept;
  logic [MAX_WORDS-1:0][15:0] words;
  logic [WCNT_W-1:0]          n;
  logic                       blk_end;
  logic                       do_finish;
  logic                       do_run;
  stage_t                     run_stage;
  logic                       stopped;
  logic [2:0]                 raw;
  logic [15:0]                value;
  logic [7:0]                 args_left;

  assign accept = in_valid && !q_full;

  always_comb begin
    phase_nxt     = phase_r;
    purpose_nxt   = purpose_r;
    opcode_nxt    = opcode_r;
    mag_nxt       = mag_r;
    sign_nxt      = sign_r;
    long_left_nxt = long_left_r;
    call_left_nxt = call_left_r;
    words         = '0;
    n             = '0;
    blk_end       = 1'b0;
    do_finish     = 1'b0;
    do_run        = 1'b0;
    run_stage     = ST_FETCH;
    stopped       = 1'b0;
    raw           = '0;
    value         = '0;
    args_left     = '0;

    case (phase_r)
      PH_OPCODE: begin
        if (in_byte == TERM_BYTE) begin
          n       = WCNT_W'(1);
          blk_end = 1'b1;
        end else begin
          opcode_nxt = in_byte;
          if (in_byte[7]) begin
            words[n[WIDX_W-1:0]] = cfg.push_locals;
            n = n + WCNT_W'(1);
          end
          do_run    = 1'b1;
          run_stage = ST_FETCH;
        end
      end
      PH_INT_FIRST: begin
        sign_nxt = in_byte[7];
        if (in_byte[6:5] == 2'b11) begin
          mag_nxt       = '0;
          long_left_nxt = in_byte[4:0];
          if (in_byte[4:0] == 5'd0) begin
            do_finish = 1'b1;
          end else begin
            phase_nxt = PH_INT_LONG;
          end
        end else if (in_byte[6]) begin
          mag_nxt   = {10'd0, in_byte[5:0]};
          phase_nxt = PH_INT_SECOND;
        end else begin
          mag_nxt   = {10'd0, in_byte[5:0]};
          do_finish = 1'b1;
        end
      end
      PH_INT_SECOND: begin
        mag_nxt   = {mag_r[7:0], in_byte};
        do_finish = 1'b1;
      end
      PH_INT_LONG: begin
        // only the low 16 bits of the magnitude ever reach a word
        mag_nxt = {mag_r[7:0], in_byte};
        if (long_left_r != 5'd0) begin
          long_left_nxt = long_left_r - 5'd1;
        end
        if (long_left_nxt == 5'd0) begin
          do_finish = 1'b1;
        end
      end
      PH_COUNT: begin
        words[n[WIDX_W-1:0]] = {8'd0, in_byte};
        n = n + WCNT_W'(1);
        call_left_nxt = in_byte;
        if (in_byte != 8'd0) begin
          phase_nxt   = PH_INT_FIRST;
          purpose_nxt = PU_ARG;
        end else begin
          do_run    = 1'b1;
          run_stage = ST_POST;
        end
      end
      default: begin
        phase_nxt = PH_OPCODE;
      end
    endcase

    if (do_finish) begin
      value = sign_nxt ? (16'd0 - mag_nxt) : mag_nxt;
      words[n[WIDX_W-1:0]] = value;
      n = n + WCNT_W'(1);
      case (purpose_r)
        PU_FETCH: begin
          do_run    = 1'b1;
          run_stage = ST_CREATE;
        end
        PU_CREATE: begin
          do_run    = 1'b1;
          run_stage = ST_BASE;
        end
        PU_CONST: begin
          do_run    = 1'b1;
          run_stage = ST_POST;
        end
        default: begin
          args_left     = (call_left_r != 8'd0) ? call_left_r - 8'd1 : 8'd0;
          call_left_nxt = args_left;
          if (args_left != 8'd0) begin
            phase_nxt   = PH_INT_FIRST;
            purpose_nxt = PU_ARG;
          end else begin
            do_run    = 1'b1;
            run_stage = ST_POST;
          end
        end
      endcase
    end

    // walk the remaining flags of the pending opcode
    if (do_run) begin
      if (run_stage == ST_FETCH && opcode_nxt[6]) begin
        words[n[WIDX_W-1:0]] = cfg.fetch_property;
        n = n + WCNT_W'(1);
        phase_nxt   = PH_INT_FIRST;
        purpose_nxt = PU_FETCH;
        stopped     = 1'b1;
      end
      if (!stopped && run_stage inside {ST_FETCH, ST_CREATE} && opcode_nxt[5]) begin
        words[n[WIDX_W-1:0]] = cfg.create_property;
        n = n + WCNT_W'(1);
        phase_nxt   = PH_INT_FIRST;
        purpose_nxt = PU_CREATE;
        stopped     = 1'b1;
      end
      if (!stopped && run_stage != ST_POST) begin
        raw = opcode_nxt[2:0];
        if (raw != 3'd0) begin
          words[n[WIDX_W-1:0]] = {13'd0, raw};
          n = n + WCNT_W'(1);
        end
        if (raw == cfg.base_push_const) begin
          phase_nxt   = PH_INT_FIRST;
          purpose_nxt = PU_CONST;
          stopped     = 1'b1;
        end else if (raw == cfg.base_lazy_call) begin
          phase_nxt = PH_COUNT;
          stopped   = 1'b1;
        end
      end
      if (!stopped) begin
        if (opcode_nxt[4]) begin
          words[n[WIDX_W-1:0]] = cfg.store;
          n = n + WCNT_W'(1);
        end
        if (opcode_nxt[3]) begin
          words[n[WIDX_W-1:0]] = cfg.pop;
          n = n + WCNT_W'(1);
        end
        phase_nxt = PH_OPCODE;
      end
    end
  end

  assign push               = accept && (n != '0);
  assign push_job.words     = words;
  assign push_job.cnt       = n;
  assign push_job.block_end = blk_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPCODE;
      purpose_r   <= PU_FETCH;
      opcode_r    <= '0;
      mag_r       <= '0;
      sign_r      <= 1'b0;
      long_left_r <= '0;
      call_left_r <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      purpose_r   <= purpose_nxt;
      opcode_r    <= opcode_nxt;
      mag_r       <= mag_nxt;
      sign_r      <= sign_nxt;
      long_left_r <= long_left_nxt;
      call_left_r <= call_left_nxt;
    end
  end

endmodule

>>> rtl/bbe_queue.sv
module bbe_queue
  import bbe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic empty,
  output logic full
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'((32'(wr_ptr_r) + 1) % QDEPTH) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QPTR_W'((32'(rd_ptr_r) + 1) % QDEPTH) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("job pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("job popped from empty queue");

endmodule

>>> rtl/bbe_back.sv
module bbe_back
  import bbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        head_job,
  input  logic        q_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_word,
  output logic        out_block_end,
  output logic        out_last
);

  logic [WIDX_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_word_r;
  logic              out_block_end_r;
  logic              out_last_r;
  logic              load;
  logic              take;
  logic              word_last;

  // output register is free when empty or being taken this cycle
  assign load      = !out_valid_r || !out_stall;
  assign take      = load && !q_empty;
  assign word_last = ({1'b0, idx_r} == head_job.cnt - WCNT_W'(1));
  assign pop       = take && word_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = !q_empty;
    end
    if (take) begin
      idx_nxt = word_last ? '0 : idx_r + WIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word_r      <= head_job.words[idx_r];
      out_block_end_r <= head_job.block_end;
      out_last_r      <= word_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;
  assign out_block_end = out_block_end_r;
  assign out_last      = out_last_r;

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> ({1'b0, idx_r} < head_job.cnt))
    else $error("word index beyond job length");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_block_end_r |-> out_last_r)
    else $error("block end word not marked last");

endmodule

>>> rtl/bytecode_block_expander.sv
// Expands a compact code block, one byte per input word, into 16-bit code words.
// The front end takes a byte whenever the four-entry job queue has room, decodes
// it against the current opcode or integer state and queues the words that byte
// causes (up to four) as one job; a byte that causes none queues nothing. The
// back end delivers one word per cycle from the queue through an output register
// while out_stall is low; a word passes through its queue entry and then the
// output register. Sustained input rate is one byte per cycle while bytes cause at
// most one word each and the output is not stalled; bytes that cause more words are
// held back by the full queue. Byte 0xFF where an opcode is expected closes the
// block with a single zero word flagged block_end. Registers are to be written
// through the cfg port while idle; the block itself does not enforce this.
module bytecode_block_expander
  import bbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_code_word,
  output logic               out_block_end,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t        cfg_r, cfg_nxt;
  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        head_job;
  logic [15:0] out_word;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_PUSH_LOCALS:     cfg_nxt.push_locals     = cfg_data;
        CFG_FETCH_PROPERTY:  cfg_nxt.fetch_property  = cfg_data;
        CFG_CREATE_PROPERTY: cfg_nxt.create_property = cfg_data;
        CFG_STORE:           cfg_nxt.store           = cfg_data;
        CFG_POP:             cfg_nxt.pop             = cfg_data;
        CFG_BASE_PUSH_CONST: cfg_nxt.base_push_const = cfg_data[2:0];
        CFG_BASE_LAZY_CALL:  cfg_nxt.base_lazy_call  = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.push_locals     <= '0;
      cfg_r.fetch_property  <= '0;
      cfg_r.create_property <= '0;
      cfg_r.store           <= '0;
      cfg_r.pop             <= '0;
      cfg_r.base_push_const <= 3'd1;
      cfg_r.base_lazy_call  <= 3'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bbe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  bbe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  bbe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_job      (head_job),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .out_block_end (out_block_end),
    .out_last      (out_last)
  );

  assign out_code_word = $signed(out_word);

endmodule

>>> verif/tb_bytecode_block_expander.sv
`timescale 1ns / 100ps

module tb_bytecode_block_expander;
  import bbe_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 70;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_code_word;
  logic               out_block_end;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = 3'd0;
  logic [15:0]        cfg_data = 16'h0000;

  bytecode_block_expander dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_word (out_code_word),
    .out_block_end (out_block_end),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic [15:0] word;
    logic        block_end;
    logic        last;
  } code_word_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    logic [2:0]  n;
    logic [15:0] w0;
    logic        term;
  } script_row_t;

  code_word_t  words_due [$];
  script_row_t script [25];

  // expander model state
  cfg_t        regs;
  phase_t      ph;
  logic [7:0]  op_byte;
  logic [31:0] mag;
  logic        neg;
  logic [4:0]  long_left;
  logic [7:0]  args_left;
  purpose_t    why;
  logic [15:0] step_words [MAX_WORDS];
  int          step_cnt;
  logic        step_end;

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int fail_count = 0;
  int bytes_sent = 0;
  int words_checked = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  function automatic void push_word(logic [15:0] w);
    if (step_cnt < MAX_WORDS) begin
      step_words[step_cnt] = w;
      step_cnt++;
    end
  endfunction

  function automatic void open_integer(purpose_t p);
    why = p;
    ph  = PH_INT_FIRST;
  endfunction

  // walk the opcode's flags from the given point on
  function automatic void expand_from(stage_t st);
    logic [2:0] base;
    base = op_byte[2:0];
    if (st <= ST_FETCH && op_byte[6]) begin
      push_word(regs.fetch_property);
      open_integer(PU_FETCH);
      return;
    end
    if (st <= ST_CREATE && op_byte[5]) begin
      push_word(regs.create_property);
      open_integer(PU_CREATE);
      return;
    end
    if (st <= ST_BASE) begin
      if (base != 3'd0) push_word({13'd0, base});
      // a zero base op is silent but still matches the registers
      if (base == regs.base_push_const) begin
        open_integer(PU_CONST);
        return;
      end
      if (base == regs.base_lazy_call) begin
        ph = PH_COUNT;
        return;
      end
    end
    if (op_byte[4]) push_word(regs.store);
    if (op_byte[3]) push_word(regs.pop);
    ph = PH_OPCODE;
  endfunction

  function automatic void close_integer();
    logic [31:0] v;
    v = neg ? (32'd0 - mag) : mag;
    push_word(v[15:0]);
    case (why)
      PU_FETCH:  expand_from(ST_CREATE);
      PU_CREATE: expand_from(ST_BASE);
      PU_CONST:  expand_from(ST_POST);
      default: begin
        if (args_left != 8'd0) args_left--;
        if (args_left != 8'd0) open_integer(PU_ARG);
        else expand_from(ST_POST);
      end
    endcase
  endfunction

  function automatic void expand_byte(logic [7:0] b);
    step_cnt = 0;
    step_end = 1'b0;
    case (ph)
      PH_OPCODE: begin
        if (b == TERM_BYTE) begin
          push_word(16'h0000);
          step_end = 1'b1;
        end else begin
          op_byte = b;
          if (b[7]) push_word(regs.push_locals);
          expand_from(ST_FETCH);
        end
      end
      PH_INT_FIRST: begin
        neg = b[7];
        if (b[6:5] == 2'b11) begin
          mag       = 32'd0;
          long_left = b[4:0];
          if (long_left == 5'd0) close_integer();
          else ph = PH_INT_LONG;
        end else if (b[6]) begin
          mag = {26'd0, b[5:0]};
          ph  = PH_INT_SECOND;
        end else begin
          mag = {26'd0, b[5:0]};
          close_integer();
        end
      end
      PH_INT_SECOND: begin
        mag = {mag[23:0], b};
        close_integer();
      end
      PH_INT_LONG: begin
        mag = {mag[23:0], b};
        if (long_left != 5'd0) long_left--;
        if (long_left == 5'd0) close_integer();
      end
      PH_COUNT: begin
        push_word({8'd0, b});
        args_left = b;
        if (b != 8'd0) open_integer(PU_ARG);
        else expand_from(ST_POST);
      end
      default: ph = PH_OPCODE;
    endcase
    for (int k = 0; k < step_cnt; k++)
      words_due.push_back('{step_words[k], step_end, k == step_cnt - 1});
  endfunction

  // mostly well-formed streams: the byte fits what the expander waits for
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    int         roll;
    b    = 8'($urandom);
    roll = $urandom_range(99);
    if (roll >= 8 || ph == PH_COUNT) begin
      case (ph)
        PH_OPCODE: if (roll < 12) b = TERM_BYTE;
        PH_INT_FIRST: begin
          case ($urandom_range(9))
            0, 1, 2, 3: b[6] = 1'b0;
            4, 5, 6:    b[6:5] = 2'b10;
            default: begin
              b[6:5] = 2'b11;
              if ($urandom_range(19) != 0) b[4:0] = 5'($urandom_range(0, 4));
            end
          endcase
        end
        PH_COUNT: begin
          if ($urandom_range(79) == 0) b = 8'($urandom_range(128, 255));
          else if ($urandom_range(29) == 0) b = 8'($urandom_range(4, 24));
          else b = 8'($urandom_range(0, 3));
        end
        default: ;
      endcase
    end
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    expand_byte(b);
    bytes_sent++;
  endtask

  // bytes that leave no word may still be in flight: wait on after the last expected word
  task automatic drain();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input int setting);
    logic [15:0] d;
    for (logic [3:0] idx = 0; idx < 8; idx++) begin
      case (setting)
        1: d = (idx[2:0] == CFG_BASE_PUSH_CONST) ? 16'hFFF8 : 16'hFFFF;
        2: begin
          if (idx[2:0] == CFG_BASE_LAZY_CALL) d = 16'h0000;
          else if (idx[2:0] == CFG_BASE_PUSH_CONST) d = 16'h0007;
          else d = 16'h8000;
        end
        default: d = 16'($urandom);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx[2:0];
      cfg_data  <= d;
      do @(posedge clk); while (!cfg_ready);
      // index 7 is unmapped and must leave every register alone
      case (idx[2:0])
        CFG_PUSH_LOCALS:     regs.push_locals     = d;
        CFG_FETCH_PROPERTY:  regs.fetch_property  = d;
        CFG_CREATE_PROPERTY: regs.create_property = d;
        CFG_STORE:           regs.store           = d;
        CFG_POP:             regs.pop             = d;
        CFG_BASE_PUSH_CONST: regs.base_push_const = d[2:0];
        CFG_BASE_LAZY_CALL:  regs.base_lazy_call  = d[2:0];
        default: ;
      endcase
      reg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < out_idle_pct);

  always @(posedge clk) begin
    code_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (words_due.size() == 0) begin
        note_failure($sformatf("unexpected word %04h end %b last %b",
                               out_code_word, out_block_end, out_last));
      end else begin
        want = words_due.pop_front();
        if (out_code_word !== want.word || out_block_end !== want.block_end ||
            out_last !== want.last)
          note_failure($sformatf("got %04h end %b last %b, want %04h end %b last %b",
                                 out_code_word, out_block_end, out_last,
                                 want.word, want.block_end, want.last));
      end
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("tb_bytecode_block_expander: errors");
    $finish;
  end

  initial begin
    regs.push_locals     = 16'h0000;
    regs.fetch_property  = 16'h0000;
    regs.create_property = 16'h0000;
    regs.store           = 16'h0000;
    regs.pop             = 16'h0000;
    regs.base_push_const = 3'd1;
    regs.base_lazy_call  = 3'd2;
    ph        = PH_OPCODE;
    op_byte   = 8'h00;
    mag       = 32'd0;
    neg       = 1'b0;
    long_left = 5'd0;
    args_left = 8'd0;
    why       = PU_FETCH;

    // run on reset registers: push const is 1, lazy call is 2, codes are 0
    script = '{
      '{8'hFF, 1'b1, 3'd1, 16'h0000, 1'b1},  // terminator
      '{8'h00, 1'b1, 3'd0, 16'h0000, 1'b0},  // empty opcode
      '{8'h01, 1'b1, 3'd1, 16'h0001, 1'b0},
      '{8'h3F, 1'b1, 3'd1, 16'h003F, 1'b0},  // largest short
      '{8'h01, 1'b1, 3'd1, 16'h0001, 1'b0},
      '{8'hBF, 1'b1, 3'd1, 16'hFFC1, 1'b0},  // negative short
      '{8'h02, 1'b1, 3'd1, 16'h0002, 1'b0},
      '{8'h02, 1'b1, 3'd1, 16'h0002, 1'b0},  // count
      '{8'h61, 1'b1, 3'd0, 16'h0000, 1'b0},
      '{8'hFF, 1'b1, 3'd1, 16'h00FF, 1'b0},  // 0xff as data
      '{8'hE0, 1'b1, 3'd1, 16'h0000, 1'b0},  // negative zero-length long
      '{8'hF8, 1'b1, 3'd2, 16'h0000, 1'b0},
      '{8'h5F, 1'b1, 3'd0, 16'h0000, 1'b0},
      '{8'hFF, 1'b1, 3'd2, 16'h1FFF, 1'b0},  // largest two-byte
      '{8'hDF, 1'b1, 3'd0, 16'h0000, 1'b0},
      '{8'hFF, 1'b1, 3'd3, 16'hE001, 1'b0},
      '{8'h01, 1'b1, 3'd1, 16'h0001, 1'b0},
      '{8'h65, 1'b1, 3'd0, 16'h0000, 1'b0},  // long form, accumulator wraps
      '{8'h12, 1'b0, 3'd0, 16'h0000, 1'b0},
      '{8'h34, 1'b0, 3'd0, 16'h0000, 1'b0},
      '{8'h56, 1'b0, 3'd0, 16'h0000, 1'b0},
      '{8'h78, 1'b0, 3'd0, 16'h0000, 1'b0},
      '{8'h9A, 1'b0, 3'd0, 16'h0000, 1'b0},
      '{8'h02, 1'b1, 3'd1, 16'h0002, 1'b0},
      '{8'h00, 1'b1, 3'd1, 16'h0000, 1'b0}   // count of zero
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int setting = 0; setting < 6; setting++) begin
      case (setting)
        0, 1: begin
          in_idle_pct  = 35;
          out_idle_pct = 67;
        end
        2, 3: begin
          in_idle_pct  = 67;
          out_idle_pct = 35;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      if (setting == 0) begin
        for (int r = 0; r < 25; r++) begin
          send_byte(script[r].b);
          if (script[r].typed && (step_cnt != script[r].n || step_end != script[r].term ||
              (step_cnt > 0 && step_words[0] != script[r].w0)))
            note_failure($sformatf("row %0d: byte %02h gives %0d words, first %04h",
                                   r, script[r].b, step_cnt, step_words[0]));
        end
      end else begin
        drain();
        configure(setting);
      end
      for (int n = 0; n < PHASE_BYTES || ph != PH_OPCODE; n++) send_byte(pick_byte());
    end

    drain();
    $display("%0d bytes expanded into %0d checked words, %0d register writes, 6 settings",
             bytes_sent, words_checked, reg_writes);
    if (fail_count == 0) begin
      $display("tb_bytecode_block_expander: clean");
    end else begin
      $display("%0d failures", fail_count);
      $display("tb_bytecode_block_expander: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bbe_pkg.sv
rtl/bbe_front.sv
rtl/bbe_queue.sv
rtl/bbe_back.sv
rtl/bytecode_block_expander.sv
verif/tb_bytecode_block_expander.sv
